/* sv/qsf_pkg.sv */
// qsf_pkg: word types, op codes, span entry type and byte masking helpers
// for the quad span fill unit. No dependencies.
`default_nettype none
package qsf_pkg;

	// op codes of an input word
	localparam logic [1:0] OP_DRAW  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	// reciprocal of nine scaled by 2^20, exact for values below 2^17
	localparam int unsigned RECIP9       = 116509;
	localparam int unsigned RECIP9_SHIFT = 20;

	typedef struct packed {
		logic [1:0]  op;
		logic [7:0]  ax;
		logic [7:0]  ay;
		logic [7:0]  bx;
		logic [7:0]  by;
		logic [7:0]  cx;
		logic [7:0]  cy;
		logic [7:0]  ex;
		logic [7:0]  ey;
		logic [7:0]  fill_color;
		logic [14:0] byte_addr;
		logic [7:0]  byte_data;
	} req_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic [1:0] item_kind;
	} rsp_t;

	// one row of the span table; hi is two's complement
	typedef struct packed {
		logic [8:0] lo;
		logic [8:0] hi;
	} span_t;

	// bits of the first byte that survive a pixel write
	function automatic logic [7:0] keep_first(input logic [3:0] d);
		logic [7:0] m;
		case (d)
			4'd0: m = 8'h00;
			4'd1: m = 8'h80;
			4'd2: m = 8'hC0;
			4'd3: m = 8'hE0;
			4'd4: m = 8'hF0;
			4'd5: m = 8'hF8;
			4'd6: m = 8'hFC;
			4'd7: m = 8'hFE;
			default: m = 8'hFF;
		endcase
		return m;
	endfunction

	// bits of the second byte that survive a pixel write
	function automatic logic [7:0] keep_second(input logic [3:0] d);
		logic [7:0] m;
		case (d)
			4'd0: m = 8'h7F;
			4'd1: m = 8'h3F;
			4'd2: m = 8'h1F;
			4'd3: m = 8'h0F;
			4'd4: m = 8'h07;
			4'd5: m = 8'h03;
			4'd6: m = 8'h01;
			4'd7: m = 8'h00;
			default: m = 8'hFF;
		endcase
		return m;
	endfunction

	function automatic logic [7:0] merge_first(input logic [7:0] old, input logic [3:0] d,
			input logic [7:0] color);
		logic [8:0] v;
		logic [8:0] sh;
		v  = {1'b1, color};
		sh = v >> (d + 4'd1);
		return (old & keep_first(d)) | sh[7:0];
	endfunction

	function automatic logic [7:0] merge_second(input logic [7:0] old, input logic [3:0] d,
			input logic [7:0] color);
		logic [8:0]  v;
		logic [15:0] sh;
		logic [2:0]  n;
		v  = {1'b1, color};
		n  = 3'd7 - d[2:0];
		sh = {7'd0, v} << n;
		return (old & keep_second(d)) | sh[7:0];
	endfunction

endpackage
`default_nettype wire

/* sv/quad_span_fill_packed_9bit_unit.sv */
// quad_span_fill_packed_9bit_unit: top level; sequencer with edge walker,
// span fill and pixel read-modify-write. Depends on qsf_pkg, qsf_store, qsf_span.
//
//  channel | direction | signals                       | word
//  req     | in        | req_valid, req_ready, req     | qsf_pkg::req_t
//  rsp     | out       | rsp_valid, rsp_ready, rsp     | qsf_pkg::rsp_t
//
// After reset the store is zeroed by a pass of one byte a cycle over all
// ((ROWS*COLS-1)*9/8+2 bytes); no word is taken meanwhile. A draw walks
// each edge point, then checks each row, and paints each pixel with two store
// reads and two writes through the single store port pair.
// One word is in work at a time; a new word is taken while a result waits.
`default_nettype none
module quad_span_fill_packed_9bit_unit #(
	parameter int ROWS = 132,
	parameter int COLS = 132
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_ready,
	input  wire qsf_pkg::req_t  req,
	output logic                rsp_valid,
	input  wire logic           rsp_ready,
	output qsf_pkg::rsp_t       rsp
);
	import qsf_pkg::*;

	localparam int NPIX        = ROWS * COLS;
	localparam int STORE_BYTES = ((NPIX - 1) * 9) / 8 + 2;
	localparam int AW          = $clog2(STORE_BYTES);
	localparam int PW          = $clog2(NPIX);
	localparam int RW          = $clog2(ROWS);
	localparam int MW          = AW + 17;

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_RD, S_WINIT, S_WRD, S_WUPD, S_FRD, S_FCHK,
		S_PA, S_PQ, S_PD, S_PR1, S_PW0, S_PW1, S_DONE
	} state_t;

	state_t          state_q;
	req_t            item_q;
	rsp_t            res_q;
	rsp_t            rsp_q;
	logic            rsp_valid_q;
	logic [AW-1:0]   clr_q;
	logic [1:0]      eidx_q;
	logic [7:0]      x_q, y_q, xe_q, ye_q, dx_q, dy_q;
	logic            sxn_q, syn_q;
	logic signed [10:0] err_q;
	logic [RW-1:0]   row_q;
	logic [7:0]      col_q, cmax_q;
	logic [PW-1:0]   p_q;
	logic [AW-1:0]   a_q, q_q;
	logic [3:0]      d_q;
	logic [7:0]      b0_q, b1_q;

	logic            accept;
	logic            st_we, st_re;
	logic [AW-1:0]   st_waddr, st_raddr;
	logic [7:0]      st_wdata, st_rdata;
	logic            sp_clr, sp_we, sp_re;
	logic [RW-1:0]   sp_waddr, sp_raddr;
	span_t           sp_wdata, sp_rdata;

	logic [31:0]     req_addr32, item_addr32;
	logic            req_inrange, item_inrange;
	logic [7:0]      vx0, vy0, vx1, vy1;
	logic            y_onscr;
	logic            lo_upd, hi_upd;
	logic [7:0]      x_clamp;
	logic signed [11:0] e2;
	logic            step_x, step_y;
	logic signed [10:0] err_nx;
	logic [MW-1:0]   prod;
	logic [AW+3:0]   rem9;
	logic [31:0]     p_first;

	assign req_ready = (state_q == S_IDLE);
	assign accept    = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign req_addr32   = 32'(req.byte_addr);
	assign item_addr32  = 32'(item_q.byte_addr);
	assign req_inrange  = req_addr32 < 32'(STORE_BYTES);
	assign item_inrange = item_addr32 < 32'(STORE_BYTES);

	// edge endpoints: A-B, B-C, C-E, E-A
	always_comb begin
		case (eidx_q)
			2'd0: begin
				vx0 = item_q.ax; vy0 = item_q.ay; vx1 = item_q.bx; vy1 = item_q.by;
			end
			2'd1: begin
				vx0 = item_q.bx; vy0 = item_q.by; vx1 = item_q.cx; vy1 = item_q.cy;
			end
			2'd2: begin
				vx0 = item_q.cx; vy0 = item_q.cy; vx1 = item_q.ex; vy1 = item_q.ey;
			end
			default: begin
				vx0 = item_q.ex; vy0 = item_q.ey; vx1 = item_q.ax; vy1 = item_q.ay;
			end
		endcase
	end

	// span update and Bresenham step for the current point
	assign y_onscr = {1'b0, y_q} < 9'(ROWS);
	assign x_clamp = ({1'b0, x_q} < 9'(COLS)) ? x_q : 8'(COLS - 1);
	assign lo_upd  = {1'b0, x_q} < sp_rdata.lo;
	assign hi_upd  = $signed({2'b00, x_q}) > $signed({sp_rdata.hi[8], sp_rdata.hi});
	assign e2      = 12'(err_q) <<< 1;
	assign step_x  = e2 > -$signed({4'd0, dy_q});
	assign step_y  = e2 < $signed({4'd0, dx_q});
	always_comb begin
		err_nx = err_q;
		if (step_x) begin
			err_nx = err_nx - $signed({3'd0, dy_q});
		end
		if (step_y) begin
			err_nx = err_nx + $signed({3'd0, dx_q});
		end
	end

	// byte address modulo nine by reciprocal
	assign prod    = MW'(a_q) * MW'(RECIP9);
	assign rem9    = {4'd0, a_q} - {1'b0, q_q, 3'd0} - {4'd0, q_q};
	assign p_first = 32'(sp_rdata.lo) * 32'(ROWS) + 32'(row_q);

	// memory port control
	always_comb begin
		st_we    = 1'b0;
		st_waddr = clr_q;
		st_wdata = 8'd0;
		st_re    = 1'b0;
		st_raddr = a_q;
		sp_clr   = 1'b0;
		sp_we    = 1'b0;
		sp_waddr = y_q[RW-1:0];
		sp_wdata.lo = lo_upd ? {1'b0, x_q} : sp_rdata.lo;
		sp_wdata.hi = hi_upd ? {1'b0, x_clamp} : sp_rdata.hi;
		sp_re    = 1'b0;
		sp_raddr = y_q[RW-1:0];
		case (state_q)
			S_CLR: begin
				st_we = 1'b1;
			end
			S_IDLE: begin
				if (accept) begin
					case (req.op)
						OP_DRAW: sp_clr = 1'b1;
						OP_WRITE: begin
							st_we    = req_inrange;
							st_waddr = req_addr32[AW-1:0];
							st_wdata = req.byte_data;
						end
						OP_READ: begin
							st_re    = req_inrange;
							st_raddr = req_addr32[AW-1:0];
						end
						default: ;
					endcase
				end
			end
			S_WRD: sp_re = y_onscr;
			S_WUPD: sp_we = y_onscr;
			S_FRD: begin
				sp_re    = 1'b1;
				sp_raddr = row_q;
			end
			S_PD: st_re = 1'b1;
			S_PR1: begin
				st_re    = 1'b1;
				st_raddr = a_q + AW'(1);
			end
			S_PW0: begin
				st_we    = 1'b1;
				st_waddr = a_q;
				st_wdata = merge_first(b0_q, d_q, item_q.fill_color);
			end
			S_PW1: begin
				st_we    = 1'b1;
				st_waddr = a_q + AW'(1);
				st_wdata = merge_second(b1_q, d_q, item_q.fill_color);
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			rsp_valid_q <= 1'b0;
			eidx_q      <= '0;
			row_q       <= '0;
		end else begin
			// a result taken while the next one is being loaded stays valid
			if (rsp_valid_q && rsp_ready && state_q != S_DONE) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(STORE_BYTES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						item_q          <= req;
						res_q.item_kind <= req.op;
						res_q.read_data <= 8'd0;
						eidx_q          <= 2'd0;
						case (req.op)
							OP_DRAW: state_q <= S_WINIT;
							OP_READ: state_q <= S_RD;
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_RD: begin
					res_q.read_data <= item_inrange ? st_rdata : 8'd0;
					state_q         <= S_DONE;
				end
				S_WINIT: begin
					x_q     <= vx0;
					y_q     <= vy0;
					xe_q    <= vx1;
					ye_q    <= vy1;
					dx_q    <= (vx1 > vx0) ? vx1 - vx0 : vx0 - vx1;
					dy_q    <= (vy1 > vy0) ? vy1 - vy0 : vy0 - vy1;
					sxn_q   <= vx0 > vx1;
					syn_q   <= vy0 > vy1;
					err_q   <= $signed({3'd0, ((vx1 > vx0) ? vx1 - vx0 : vx0 - vx1)})
						- $signed({3'd0, ((vy1 > vy0) ? vy1 - vy0 : vy0 - vy1)});
					state_q <= S_WRD;
				end
				S_WRD: state_q <= S_WUPD;
				S_WUPD: begin
					if (x_q == xe_q && y_q == ye_q) begin
						if (eidx_q == 2'd3) begin
							row_q   <= '0;
							state_q <= S_FRD;
						end else begin
							eidx_q  <= eidx_q + 2'd1;
							state_q <= S_WINIT;
						end
					end else begin
						err_q <= err_nx;
						if (step_x) begin
							x_q <= sxn_q ? x_q - 8'd1 : x_q + 8'd1;
						end
						if (step_y) begin
							y_q <= syn_q ? y_q - 8'd1 : y_q + 8'd1;
						end
						state_q <= S_WRD;
					end
				end
				S_FRD: state_q <= S_FCHK;
				S_FCHK: begin
					if ($signed(sp_rdata.hi) > $signed({1'b0, sp_rdata.lo[7:0]})
							&& !sp_rdata.lo[8]) begin
						col_q   <= sp_rdata.lo[7:0];
						cmax_q  <= sp_rdata.hi[7:0];
						p_q     <= p_first[PW-1:0];
						state_q <= S_PA;
					end else if (row_q == RW'(ROWS - 1)) begin
						state_q <= S_DONE;
					end else begin
						row_q   <= row_q + RW'(1);
						state_q <= S_FRD;
					end
				end
				S_PA: begin
					a_q     <= AW'(({4'd0, p_q} + {1'b0, p_q, 3'd0}) >> 3);
					state_q <= S_PQ;
				end
				S_PQ: begin
					q_q     <= AW'(prod >> RECIP9_SHIFT);
					state_q <= S_PD;
				end
				S_PD: begin
					d_q     <= rem9[3:0];
					state_q <= S_PR1;
				end
				S_PR1: begin
					b0_q    <= st_rdata;
					state_q <= S_PW0;
				end
				S_PW0: begin
					b1_q    <= st_rdata;
					state_q <= S_PW1;
				end
				S_PW1: begin
					if (col_q != cmax_q) begin
						col_q   <= col_q + 8'd1;
						p_q     <= p_q + PW'(ROWS);
						state_q <= S_PA;
					end else if (row_q == RW'(ROWS - 1)) begin
						state_q <= S_DONE;
					end else begin
						row_q   <= row_q + RW'(1);
						state_q <= S_FRD;
					end
				end
				S_DONE: begin
					if (!rsp_valid_q || rsp_ready) begin
						rsp_q       <= res_q;
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	qsf_store #(
		.DEPTH(STORE_BYTES),
		.AW   (AW)
	) u_store (
		.clk  (clk),
		.we   (st_we),
		.waddr(st_waddr),
		.wdata(st_wdata),
		.re   (st_re),
		.raddr(st_raddr),
		.rdata(st_rdata)
	);

	qsf_span #(
		.ROWS(ROWS),
		.COLS(COLS),
		.RW  (RW)
	) u_span (
		.clk   (clk),
		.arst_n(arst_n),
		.clr   (sp_clr),
		.we    (sp_we),
		.waddr (sp_waddr),
		.wdata (sp_wdata),
		.re    (sp_re),
		.raddr (sp_raddr),
		.rdata (sp_rdata)
	);

endmodule
`default_nettype wire

/* sv/qsf_store.sv */
// qsf_store: byte-wide framebuffer memory, one write and one read port,
// registered read data. Depends on nothing.
`default_nettype none
module qsf_store #(
	parameter int DEPTH = 19602,
	parameter int AW    = 15
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [7:0]    wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [7:0]    rdata
);

	logic [7:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

/* sv/qsf_span.sv */
// qsf_span: per-row span table (min/max column) in a memory with one valid
// bit per row; an invalid row reads as empty. Depends on qsf_pkg.
`default_nettype none
module qsf_span #(
	parameter int ROWS = 132,
	parameter int COLS = 132,
	parameter int RW   = 8
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            clr,
	input  wire logic            we,
	input  wire logic [RW-1:0]   waddr,
	input  wire qsf_pkg::span_t  wdata,
	input  wire logic            re,
	input  wire logic [RW-1:0]   raddr,
	output qsf_pkg::span_t       rdata
);
	import qsf_pkg::*;

	span_t          mem [ROWS];
	logic [ROWS-1:0] valid_q;
	span_t          rd_s1;
	logic           rvld_s1;

	// table storage
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rd_s1 <= mem[raddr];
		end
	end

	// valid bits: cleared at the start of each draw, set on write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rvld_s1 <= 1'b0;
		end else begin
			if (clr) begin
				valid_q <= '0;
			end else if (we) begin
				valid_q[waddr] <= 1'b1;
			end
			if (re) begin
				rvld_s1 <= valid_q[raddr];
			end
		end
	end

	// untouched row: min is COLS+1, max is minus one
	always_comb begin
		if (rvld_s1) begin
			rdata = rd_s1;
		end else begin
			rdata.lo = 9'(COLS + 1);
			rdata.hi = '1;
		end
	end

endmodule
`default_nettype wire

/* bench/qsf_checker.sv */
// qsf_checker: watches the req and rsp channels of the quad span fill unit,
// predicts each result word from its own framebuffer copy and compares.
// Depends on qsf_pkg.
`default_nettype none
module qsf_checker #(
	parameter int ROWS = 132,
	parameter int COLS = 132
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	input  wire logic          req_ready,
	input  wire qsf_pkg::req_t req,
	input  wire logic          rsp_valid,
	input  wire logic          rsp_ready,
	input  wire qsf_pkg::rsp_t rsp,
	output int                 errors,
	output int                 pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import qsf_pkg::*;

	localparam int NPIX        = ROWS * COLS;
	localparam int STORE_BYTES = ((NPIX - 1) * 9) / 8 + 2;

	logic [7:0] fb_model [STORE_BYTES];
	int         row_lo [ROWS];
	int         row_hi [ROWS];
	rsp_t       due_rsp [$];

	// mismatch report
	task automatic report(input string what);
		errors++;
		$display("%0t ns: mismatch: %s", $realtime, what);
	endtask

	// widen one row span from an edge point
	function automatic void touch_span(input int x, input int y);
		if (y >= 0 && y < ROWS) begin
			if (x < row_lo[y])
				row_lo[y] = (x >= 0) ? x : 0;
			if (x > row_hi[y])
				row_hi[y] = (x < COLS) ? x : COLS - 1;
		end
	endfunction

	// Bresenham walk of one closed edge
	function automatic void trace_edge(input int x, input int y, input int x1, input int y1);
		int dx, dy, sx, sy, err, e2;
		dx = (x1 > x) ? x1 - x : x - x1;
		dy = (y1 > y) ? y1 - y : y - y1;
		sx = (x > x1) ? -1 : 1;
		sy = (y > y1) ? -1 : 1;
		err = dx - dy;
		forever begin
			touch_span(x, y);
			if (x == x1 && y == y1)
				return;
			e2 = 2 * err;
			if (e2 > -dy) begin
				err -= dy;
				x += sx;
			end
			if (e2 < dx) begin
				err += dx;
				y += sy;
			end
		end
	endfunction

	// two-byte read-modify-write of one 9-bit pixel
	function automatic void paint_pixel(input int col, input int row, input logic [7:0] color);
		int          a, d;
		logic [15:0] v;
		logic [7:0]  k1, k2;
		a = ((col * ROWS + row) * 9) / 8;
		d = a % 9;
		v = {8'h01, color};
		if (a + 1 >= STORE_BYTES)
			return;
		k1 = (d == 8) ? 8'hFF : ~(8'hFF >> d);
		k2 = (d == 8) ? 8'hFF : (8'h7F >> d);
		fb_model[a]     = (fb_model[a] & k1) | 8'(v >> (1 + d));
		fb_model[a + 1] = (fb_model[a + 1] & k2) | 8'(v << (7 - (d & 7)));
	endfunction

	function automatic void fill_quad(input req_t w);
		for (int r = 0; r < ROWS; r++) begin
			row_lo[r] = COLS + 1;
			row_hi[r] = -1;
		end
		trace_edge(w.ax, w.ay, w.bx, w.by);
		trace_edge(w.bx, w.by, w.cx, w.cy);
		trace_edge(w.cx, w.cy, w.ex, w.ey);
		trace_edge(w.ex, w.ey, w.ax, w.ay);
		for (int r = 0; r < ROWS; r++)
			if (row_hi[r] > row_lo[r])
				for (int c = row_lo[r]; c <= row_hi[r]; c++)
					paint_pixel(c, r, w.fill_color);
	endfunction

	// expected result of one accepted word
	function automatic rsp_t predict_word(input req_t w);
		rsp_t o;
		o.read_data = '0;
		o.item_kind = w.op;
		case (w.op)
			OP_DRAW:  fill_quad(w);
			OP_WRITE: if (w.byte_addr < STORE_BYTES) fb_model[w.byte_addr] = w.byte_data;
			OP_READ:  if (w.byte_addr < STORE_BYTES) o.read_data = fb_model[w.byte_addr];
			default: ;
		endcase
		return o;
	endfunction

	initial begin
		errors = 0;
		foreach (fb_model[i])
			fb_model[i] = '0;
	end

	assign pending = due_rsp.size();

	// observe both channels
	always @(posedge clk) begin
		rsp_t e;
		if (arst_n) begin
			if (req_valid && req_ready)
				due_rsp.push_back(predict_word(req));
			if (rsp_valid && rsp_ready) begin
				if (due_rsp.size() == 0)
					report($sformatf("unexpected word kind %0d", rsp.item_kind));
				else begin
					e = due_rsp.pop_front();
					if (rsp.item_kind !== e.item_kind)
						report($sformatf("item_kind %0d, want %0d", rsp.item_kind, e.item_kind));
					if (rsp.read_data !== e.read_data)
						report($sformatf("read_data %h, want %h", rsp.read_data, e.read_data));
				end
			end
		end
	end
endmodule
`default_nettype wire

/* bench/testbench.sv */
// testbench: stimulus and verdict for quad_span_fill_packed_9bit_unit.
// Depends on qsf_pkg, the unit's RTL and qsf_checker.
`default_nettype none
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import qsf_pkg::*;

	localparam int ROWS        = 132;
	localparam int COLS        = 132;
	localparam int STORE_BYTES = ((ROWS * COLS - 1) * 9) / 8 + 2;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;
	int   errors, pending;
	int   n_draw, n_write, n_read;

	always #5 clk = ~clk;

	quad_span_fill_packed_9bit_unit #(.ROWS(ROWS), .COLS(COLS)) uut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
	);

	qsf_checker #(.ROWS(ROWS), .COLS(COLS)) chk (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
		.errors(errors), .pending(pending)
	);

	// send one word after a random gap; valid stays up when there is no gap
	task automatic send_word(input req_t w);
		int gap;
		gap = $urandom_range(0, 15);
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req <= w;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		case (w.op)
			OP_DRAW:  n_draw++;
			OP_WRITE: n_write++;
			OP_READ:  n_read++;
			default: ;
		endcase
	endtask

	function automatic req_t quad_word(input int ax, ay, bx, by, cx, cy, ex, ey, col);
		req_t w;
		w = req_t'({$urandom, $urandom, $urandom, $urandom});
		w.op = OP_DRAW;
		w.ax = 8'(ax); w.ay = 8'(ay); w.bx = 8'(bx); w.by = 8'(by);
		w.cx = 8'(cx); w.cy = 8'(cy); w.ex = 8'(ex); w.ey = 8'(ey);
		w.fill_color = 8'(col);
		return w;
	endfunction

	function automatic req_t byte_word(input logic [1:0] op, input int addr, input int data);
		req_t w;
		w = req_t'({$urandom, $urandom, $urandom, $urandom});
		w.op = op;
		w.byte_addr = 15'(addr);
		w.byte_data = 8'(data);
		return w;
	endfunction

	// draws are kept small mostly so the run stays short
	function automatic req_t rand_quad();
		int x, y, s;
		s = ($urandom_range(0, 9) == 0) ? 255 : 24;
		x = $urandom_range(0, 255 - s);
		y = $urandom_range(0, 140);
		return quad_word(x + $urandom_range(0, s), y + $urandom_range(0, s / 2),
			x + $urandom_range(0, s), y + $urandom_range(0, s / 2),
			x + $urandom_range(0, s), y + $urandom_range(0, s / 2),
			x + $urandom_range(0, s), y + $urandom_range(0, s / 2),
			$urandom_range(0, 255));
	endfunction

	// result side stalls
	initial begin
		forever begin
			@(posedge clk);
			if (rsp_valid && rsp_ready)
				rsp_ready <= 1'b0;
			else if (!rsp_ready) begin
				repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15)) @(posedge clk);
				rsp_ready <= 1'b1;
			end
		end
	end

	initial begin
		#400ms;
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		int a, waited;
		n_draw = 0; n_write = 0; n_read = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed: byte extremes, corners, unused op, degenerate and clamped quads
		send_word(byte_word(OP_READ, 0, 0));
		send_word(byte_word(OP_WRITE, 0, 8'hFF));
		send_word(byte_word(OP_READ, 0, 0));
		send_word(byte_word(OP_WRITE, STORE_BYTES - 1, 8'hA5));
		send_word(byte_word(OP_READ, STORE_BYTES - 1, 0));
		send_word(byte_word(OP_WRITE, STORE_BYTES, 8'h5A));
		send_word(byte_word(OP_READ, STORE_BYTES, 0));
		send_word(byte_word(OP_WRITE, 15'h7FFF, 8'h00));
		send_word(byte_word(OP_READ, 15'h7FFF, 0));
		send_word(byte_word(2'd3, 15'h7FFF, 8'hFF));
		send_word(quad_word(5, 5, 5, 5, 5, 5, 5, 5, 8'h11));
		send_word(quad_word(3, 3, 3, 12, 3, 12, 3, 3, 8'h22));
		send_word(quad_word(0, 0, 10, 0, 10, 6, 0, 6, 8'h00));
		send_word(quad_word(120, 125, 255, 131, 255, 140, 120, 255, 8'hFF));
		send_word(quad_word(200, 10, 255, 10, 255, 20, 200, 20, 8'h77));
		send_word(quad_word(0, 0, 255, 0, 255, 255, 0, 255, 8'hC3));
		send_word(quad_word(10, 20, 40, 22, 35, 50, 8, 45, 8'h3C));
		send_word(byte_word(OP_READ, 100, 0));
		send_word(byte_word(OP_READ, STORE_BYTES - 1, 0));

		// random mix, draws weighted towards small quads
		for (int i = 0; i < 60; i++) begin
			a = ($urandom_range(0, 1)) ? $urandom_range(0, 4000) : $urandom_range(0, 32767);
			case ($urandom_range(0, 9))
				0, 1, 2, 3: send_word(rand_quad());
				4, 5:       send_word(byte_word(OP_WRITE, a, $urandom_range(0, 255)));
				9:          send_word(byte_word(2'd3, a, $urandom_range(0, 255)));
				default:    send_word(byte_word(OP_READ, a, 0));
			endcase
		end
		// read back a stretch of drawn memory
		for (int i = 0; i < 20; i++)
			send_word(byte_word(OP_READ, $urandom_range(0, 3000), 0));
		req_valid <= 1'b0;

		waited = 0;
		while (pending != 0 && waited < 500000) begin
			@(posedge clk);
			waited++;
		end
		repeat (20) @(posedge clk);
		$display("Covered %0d draws, %0d byte writes, %0d byte reads plus unused ops.",
			n_draw, n_write, n_read);
		if (errors == 0 && pending == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
`default_nettype wire

/* files.f */
sv/qsf_pkg.sv
sv/qsf_store.sv
sv/qsf_span.sv
sv/quad_span_fill_packed_9bit_unit.sv
bench/qsf_checker.sv
bench/testbench.sv
